// ===== hw/rtl/lgs_pkg.sv =====
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types, codes and the B3/S23 cell rule for the life generation block.
// ----------------------------------------------------------------------------
`default_nettype none

package lgs_pkg;

  localparam int CFG_W = 7;
  localparam int ROW_W = 6;
  localparam int COL_W = 6;

  localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] KEEP_COUNT  = 4'd2;

  typedef struct packed {
    logic [1:0]       op;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             alive_in;
  } lgs_in_t;

  typedef struct packed {
    logic       alive_out;
    logic [1:0] op_echo;
    logic       range_error;
  } lgs_out_t;

  function automatic logic life_next(input logic [7:0] nb, input logic alive);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'b000, nb[i]};
    end
    return (n == BIRTH_COUNT) || ((n == KEEP_COUNT) && alive);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lgs_cell_mem.sv =====
// ----------------------------------------------------------------------------
// lgs_cell_mem
// Row-wide cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lgs_cell_mem #(
  parameter int DW = 64,
  parameter int AW = 7
) (
  input  wire logic          clk,
  input  wire logic          wen,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          ren,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lgs_row_eval.sv =====
// ----------------------------------------------------------------------------
// lgs_row_eval
// Next state of one board row from the rows above, at and below it.
// ----------------------------------------------------------------------------
`default_nettype none

module lgs_row_eval #(
  parameter int WIDTH = 64
) (
  input  wire logic [WIDTH-1:0] above,
  input  wire logic [WIDTH-1:0] center,
  input  wire logic [WIDTH-1:0] below,
  input  wire logic [WIDTH-1:0] keep,
  output logic      [WIDTH-1:0] next_row
);

  import lgs_pkg::*;

  logic [WIDTH+1:0] ap;
  logic [WIDTH+1:0] cp;
  logic [WIDTH+1:0] bp;

  // padded by a dead cell on each side: no wraparound
  assign ap = {1'b0, above, 1'b0};
  assign cp = {1'b0, center, 1'b0};
  assign bp = {1'b0, below, 1'b0};

  always_comb begin
    for (int c = 0; c < WIDTH; c++) begin
      next_row[c] = keep[c] & life_next({ap[c+2], ap[c+1], ap[c],
                                         cp[c+2], cp[c],
                                         bp[c+2], bp[c+1], bp[c]}, center[c]);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/life_generation_step.sv =====
// ----------------------------------------------------------------------------
// life_generation_step
// Bounded B3/S23 board in two row-wide banks; cell write, cell read and
// one-generation step, one result word per input word.
// ----------------------------------------------------------------------------
//  channel | handshake             | word
//  --------+-----------------------+------------------------------------
//  in      | in_valid / in_ready   | lgs_in_t: op, row, col, alive_in
//  out     | out_valid / out_ready | lgs_out_t: alive_out, op_echo, range_error
//  cfg     | cfg_valid / cfg_ready | cfg_index (0 width, 1 height), cfg_data
//
//  Write and read pass through row read, modify/select and load; out-of-range and
//  unused ops go straight to load. A step reads one row per cycle from the current
//  bank and writes each next row to the other. A new word is accepted after its load.
//  After reset, bank 0 is cleared one row per cycle; in_ready stays low meanwhile.
//  cfg_ready is always high.
//  A result waiting on out_ready does not block the next accept.
// ----------------------------------------------------------------------------
`default_nettype none

module life_generation_step #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire lgs_pkg::lgs_in_t         in_data,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output lgs_pkg::lgs_out_t             out_data,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic                     cfg_index,
  input  wire logic [lgs_pkg::CFG_W-1:0] cfg_data
);

  import lgs_pkg::*;

  localparam int RB  = $clog2(MAX_HEIGHT);
  localparam int CB  = $clog2(MAX_WIDTH);
  localparam int AW  = RB + 1;
  localparam int SCW = $clog2(MAX_HEIGHT + 1);
  localparam int WW  = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
  localparam int HW  = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;

  localparam logic [WW-1:0]  MAX_W_V  = WW'(MAX_WIDTH);
  localparam logic [HW-1:0]  MAX_H_V  = HW'(MAX_HEIGHT);
  localparam logic [SCW-1:0] LAST_ROW = SCW'(MAX_HEIGHT - 1);
  localparam logic [SCW-1:0] SC_END   = SCW'(MAX_HEIGHT);
  localparam logic [RB-1:0]  LAST_RB  = RB'(MAX_HEIGHT - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ACCESS,
    S_STEP,
    S_DONE
  } state_t;

  state_t                state;
  logic [CFG_W-1:0]      board_width;
  logic [CFG_W-1:0]      board_height;
  logic                  bank;
  logic [SCW-1:0]        sc;
  logic                  issuing;
  logic                  b_valid;
  logic [SCW-1:0]        b_row;
  logic                  b_live;
  logic                  c_valid;
  logic [RB-1:0]         c_row;
  logic                  c_live;
  logic [MAX_WIDTH-1:0]  win_above;
  logic [MAX_WIDTH-1:0]  win_center;
  logic [MAX_WIDTH-1:0]  win_below;
  lgs_in_t               req;
  logic                  req_err;
  logic                  res_alive;

  logic [WW-1:0]         w_eff;
  logic [HW-1:0]         h_eff;
  logic [MAX_WIDTH-1:0]  colmask;
  logic                  is_access;
  logic                  acc_err;
  logic                  a_live;
  logic [SCW-1:0]        b_prev;
  logic [CB-1:0]         cidx;
  logic                  wen;
  logic [AW-1:0]         waddr;
  logic [MAX_WIDTH-1:0]  wdata;
  logic                  ren;
  logic [AW-1:0]         raddr;
  logic [MAX_WIDTH-1:0]  rdata;
  logic [MAX_WIDTH-1:0]  mod_row;
  logic [MAX_WIDTH-1:0]  incoming;
  logic [MAX_WIDTH-1:0]  keep;
  logic [MAX_WIDTH-1:0]  next_row;

  assign w_eff = (WW'(board_width) > MAX_W_V) ? MAX_W_V : WW'(board_width);
  assign h_eff = (HW'(board_height) > MAX_H_V) ? MAX_H_V : HW'(board_height);

  always_comb begin
    for (int c = 0; c < MAX_WIDTH; c++) begin
      colmask[c] = WW'(c) < w_eff;
    end
  end

  assign is_access = (in_data.op == OP_WRITE) || (in_data.op == OP_READ);
  assign acc_err   = is_access &&
                     !((HW'(in_data.row) < h_eff) && (WW'(in_data.col) < w_eff));
  assign a_live    = HW'(sc) < h_eff;
  assign b_prev    = b_row - SCW'(1);
  assign cidx      = CB'(req.col);

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    mod_row       = rdata;
    mod_row[cidx] = req.alive_in;
  end

  assign incoming = b_live ? (rdata & colmask) : '0;
  assign keep     = colmask & {MAX_WIDTH{c_live}};

  always_comb begin
    ren   = 1'b0;
    raddr = '0;
    if (in_valid && in_ready && is_access && !acc_err) begin
      ren   = 1'b1;
      raddr = {bank, RB'(in_data.row)};
    end else if ((state == S_STEP) && issuing && a_live) begin
      ren   = 1'b1;
      raddr = {bank, RB'(sc)};
    end
  end

  always_comb begin
    wen   = 1'b0;
    waddr = '0;
    wdata = '0;
    case (state)
      S_CLEAR: begin
        wen   = 1'b1;
        waddr = {1'b0, RB'(sc)};
      end
      S_ACCESS: begin
        if (req.op == OP_WRITE) begin
          wen   = 1'b1;
          waddr = {bank, RB'(req.row)};
          wdata = mod_row;
        end
      end
      S_STEP: begin
        if (c_valid) begin
          wen   = 1'b1;
          waddr = {~bank, c_row};
          wdata = next_row;
        end
      end
      default: begin
        wen = 1'b0;
      end
    endcase
  end

  lgs_cell_mem #(
    .DW (MAX_WIDTH),
    .AW (AW)
  ) u_mem (
    .clk   (clk),
    .wen   (wen),
    .waddr (waddr),
    .wdata (wdata),
    .ren   (ren),
    .raddr (raddr),
    .rdata (rdata)
  );

  lgs_row_eval #(
    .WIDTH (MAX_WIDTH)
  ) u_eval (
    .above    (win_above),
    .center   (win_center),
    .below    (win_below),
    .keep     (keep),
    .next_row (next_row)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      board_width  <= SIZE_RESET;
      board_height <= SIZE_RESET;
      bank         <= 1'b0;
      sc           <= '0;
      issuing      <= 1'b0;
      b_valid      <= 1'b0;
      c_valid      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WIDTH:  board_width  <= cfg_data;
          CFG_HEIGHT: board_height <= cfg_data;
          default:    board_width  <= board_width;
        endcase
      end
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (sc == LAST_ROW) begin
            sc    <= '0;
            state <= S_IDLE;
          end else begin
            sc <= sc + SCW'(1);
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req       <= in_data;
            req_err   <= acc_err;
            res_alive <= 1'b0;
            if (in_data.op == OP_STEP) begin
              state      <= S_STEP;
              sc         <= '0;
              issuing    <= 1'b1;
              b_valid    <= 1'b0;
              c_valid    <= 1'b0;
              win_above  <= '0;
              win_center <= '0;
              win_below  <= '0;
            end else if (is_access && !acc_err) begin
              state <= S_ACCESS;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_ACCESS: begin
          if (req.op == OP_READ) begin
            res_alive <= rdata[cidx];
          end
          state <= S_DONE;
        end
        S_STEP: begin
          // issue row reads
          if (issuing) begin
            b_valid <= 1'b1;
            b_row   <= sc;
            b_live  <= a_live;
            if (sc == SC_END) begin
              issuing <= 1'b0;
            end else begin
              sc <= sc + SCW'(1);
            end
          end else begin
            b_valid <= 1'b0;
          end
          // shift window as read data lands
          if (b_valid) begin
            win_above  <= win_center;
            win_center <= win_below;
            win_below  <= incoming;
            c_valid    <= (b_row != '0);
            c_row      <= RB'(b_prev);
            c_live     <= HW'(b_prev) < h_eff;
          end else begin
            c_valid <= 1'b0;
          end
          // last row written: swap banks
          if (c_valid && (c_row == LAST_RB)) begin
            bank  <= ~bank;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_data.alive_out   <= res_alive;
            out_data.op_echo     <= req.op;
            out_data.range_error <= req_err;
            out_valid            <= 1'b1;
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_no_rw_collide: assert property (@(posedge clk) disable iff (rst)
    !(wen && ren && (waddr == raddr)))
    else $error("read and write hit the same row in one cycle");

  a_step_other_bank: assert property (@(posedge clk) disable iff (rst)
    ((state == S_STEP) && wen) |-> (waddr[AW-1] != bank))
    else $error("step wrote into the current bank");

  a_bank_flip: assert property (@(posedge clk) disable iff (rst)
    !$stable(bank) |-> ($past(state) == S_STEP))
    else $error("bank changed outside a step");

  a_sc_bound: assert property (@(posedge clk) disable iff (rst)
    sc <= SC_END)
    else $error("row counter overran");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && (!out_valid || out_ready)) |=> (out_valid && (state == S_IDLE)))
    else $error("finished word not presented");

endmodule

`default_nettype wire
